### sv/assert_macros.svh
// Assertion macros shared by the allocator modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCSA_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCSA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

### sv/scsa_pkg.sv
package scsa_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int MAX_PAGES    = 64;
   localparam int HEADER_BYTES = 16;
   localparam int DATA_BYTES   = PAGE_BYTES - HEADER_BYTES;

   localparam int ADDR_W      = 18;
   localparam int SIZE_W      = 7;
   localparam int PAGE_W      = 7;
   localparam int PAGE_IDX_W  = 6;
   localparam int OFF_W       = 12;
   localparam int GRAN_W      = 9;
   localparam int CLASS_W     = 2;
   localparam int SLOT_W      = 7;
   localparam int NUM_CLASSES = 4;
   localparam int LINK_ADDR_W = PAGE_IDX_W + GRAN_W;
   localparam int LINK_DEPTH  = 1 << LINK_ADDR_W;

   localparam logic [PAGE_W-1:0] NO_PAGE = PAGE_W'(MAX_PAGES);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_NO_PAGE   = 2'd1;
   localparam logic [1:0] STATUS_FREED     = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [SIZE_W-1:0] alloc_size;
      logic [ADDR_W-1:0] free_address;
   } alloc_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] slot_address;
   } alloc_rsp_type;

   typedef struct packed {
      logic [OFF_W-1:0]   first_free;
      logic [CLASS_W-1:0] size_class;
      logic [PAGE_W-1:0]  next_page;
   } page_rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_OPEN,
      ST_RECORD,
      ST_LINK
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       decide;
      logic       open_init;
      logic       open_step;
      logic       alloc_commit;
      logic       free_commit;
      logic       respond;
      logic [1:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic need_open;
      logic pages_full;
      logic free_drop;
      logic rec_full;
      logic free_slack;
      logic open_last;
   } dp_stat_type;

   function automatic logic [CLASS_W-1:0] class_for(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] cls;
      if (size <= SIZE_W'(8)) begin
         cls = CLASS_W'(0);
      end else if (size <= SIZE_W'(16)) begin
         cls = CLASS_W'(1);
      end else if (size <= SIZE_W'(32)) begin
         cls = CLASS_W'(2);
      end else begin
         cls = CLASS_W'(3);
      end
      return cls;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_bytes(input logic [CLASS_W-1:0] cls);
      return SLOT_W'(8) << cls;
   endfunction

   // True when a slot at this offset would run past the data area.
   function automatic logic past_end(input logic [OFF_W-1:0] off,
                                     input logic [SLOT_W-1:0] sz);
      return ((OFF_W + 1)'(off) + (OFF_W + 1)'(sz)) > (OFF_W + 1)'(DATA_BYTES);
   endfunction

endpackage

### sv/scsa_ram.sv
module scsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/scsa_ctrl.sv
`include "assert_macros.svh"

module scsa_ctrl import scsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.is_alloc) begin
               if (!stat.need_open) begin
                  state_in = ST_RECORD;
               end else if (stat.pages_full) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OPEN;
               end
            end else if (stat.free_drop) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RECORD;
            end
         end
         ST_OPEN: begin
            if (stat.open_last) begin
               state_in = ST_RECORD;
            end
         end
         ST_RECORD: begin
            if (stat.is_alloc && !stat.rec_full) begin
               state_in = ST_LINK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.is_alloc) begin
               if (stat.need_open && stat.pages_full) begin
                  cmd.respond = 1'b1;
                  cmd.code    = STATUS_NO_PAGE;
               end else if (stat.need_open) begin
                  cmd.open_init = 1'b1;
               end
            end else if (stat.free_drop) begin
               cmd.respond = 1'b1;
               cmd.code    = STATUS_FREED;
            end
         end
         ST_OPEN: begin
            cmd.open_step = 1'b1;
         end
         ST_RECORD: begin
            if (stat.is_alloc) begin
               if (stat.rec_full) begin
                  cmd.respond = 1'b1;
                  cmd.code    = STATUS_NO_PAGE;
               end
            end else begin
               cmd.respond     = 1'b1;
               cmd.code        = STATUS_FREED;
               cmd.free_commit = !stat.free_slack;
            end
         end
         ST_LINK: begin
            cmd.alloc_commit = 1'b1;
            cmd.respond      = 1'b1;
            cmd.code         = STATUS_ALLOCATED;
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `SCSA_ASSERT_NEXT(a_accept_to_decide, start && !busy, state_ff == ST_DECIDE)
   `SCSA_ASSERT(a_commit_answers, cmd.alloc_commit || cmd.free_commit, cmd.respond)

endmodule

### sv/scsa_dpath.sv
`include "assert_macros.svh"

module scsa_dpath import scsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  alloc_req_type req_in,
   input  dp_cmd_type    cmd,
   output dp_stat_type   stat,
   output logic          rsp_valid,
   output alloc_rsp_type rsp_out
);

   localparam int REC_W = $bits(page_rec_type);

   alloc_req_type     req_ff;
   alloc_req_type     req_load_in;
   logic [PAGE_W-1:0] pg_ff;
   logic [PAGE_W-1:0] pg_in;
   logic [OFF_W-1:0]  off_ff;
   logic [OFF_W-1:0]  off_in;
   logic [PAGE_W-1:0] pages_used_ff;
   logic [PAGE_W-1:0] pages_used_in;
   logic [PAGE_W-1:0] head_ff [NUM_CLASSES];
   logic [PAGE_W-1:0] head_in [NUM_CLASSES];
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   alloc_rsp_type     rsp_ff;
   alloc_rsp_type     rsp_in;

   logic                   is_alloc;
   logic [CLASS_W-1:0]     req_cls;
   logic [PAGE_W-1:0]      sel_pg;
   logic [OFF_W-1:0]       page_off;
   page_rec_type           rec;
   logic [REC_W-1:0]       rec_rdata;
   logic [CLASS_W-1:0]     cur_cls;
   logic [SLOT_W-1:0]      cur_sz;
   logic [OFF_W-1:0]       free_off;
   logic [OFF_W-1:0]       link_rdata;
   logic                   after_full;
   logic [ADDR_W-1:0]      alloc_addr;

   logic                   rec_we;
   logic [PAGE_IDX_W-1:0]  rec_waddr;
   page_rec_type           rec_wdata;
   logic [PAGE_IDX_W-1:0]  rec_raddr;
   logic                   link_we;
   logic [LINK_ADDR_W-1:0] link_waddr;
   logic [OFF_W-1:0]       link_wdata;
   logic [LINK_ADDR_W-1:0] link_raddr;

   logic                   heads_ok;
   logic                   sweep_in_area;

   assign is_alloc = (req_ff.req_type == REQ_ALLOC);
   assign req_cls  = class_for(req_ff.alloc_size);
   assign page_off = req_ff.free_address[OFF_W-1:0];
   assign sel_pg   = is_alloc ? head_ff[req_cls]
                              : {1'b0, req_ff.free_address[ADDR_W-1:OFF_W]};
   assign rec      = page_rec_type'(rec_rdata);
   assign cur_cls  = is_alloc ? req_cls : rec.size_class;
   assign cur_sz   = slot_bytes(cur_cls);
   assign free_off = (page_off - OFF_W'(HEADER_BYTES)) & ~(OFF_W'(cur_sz) - OFF_W'(1));
   assign after_full = past_end(link_rdata, cur_sz);
   assign alloc_addr = {pg_ff[PAGE_IDX_W-1:0], {OFF_W{1'b0}}} + ADDR_W'(HEADER_BYTES)
                       + ADDR_W'(rec.first_free);

   always_comb begin
      stat            = '0;
      stat.is_alloc   = is_alloc;
      stat.need_open  = (sel_pg >= pages_used_ff);
      stat.pages_full = (pages_used_ff >= PAGE_W'(MAX_PAGES));
      stat.free_drop  = (sel_pg >= pages_used_ff) || (page_off < OFF_W'(HEADER_BYTES));
      stat.rec_full   = past_end(rec.first_free, cur_sz);
      stat.free_slack = past_end(free_off, cur_sz);
      stat.open_last  = past_end(off_ff + OFF_W'(cur_sz), cur_sz);
   end

   // Page record store: read the selected page while deciding, the current page after.
   assign rec_raddr = cmd.decide ? sel_pg[PAGE_IDX_W-1:0] : pg_ff[PAGE_IDX_W-1:0];

   always_comb begin
      rec_we    = 1'b0;
      rec_waddr = pg_ff[PAGE_IDX_W-1:0];
      rec_wdata = rec;
      if (cmd.open_init) begin
         rec_we               = 1'b1;
         rec_waddr            = pages_used_ff[PAGE_IDX_W-1:0];
         rec_wdata.first_free = '0;
         rec_wdata.size_class = req_cls;
         rec_wdata.next_page  = NO_PAGE;
      end else if (cmd.alloc_commit) begin
         rec_we               = 1'b1;
         rec_wdata.first_free = link_rdata;
         rec_wdata.size_class = req_cls;
         rec_wdata.next_page  = after_full ? NO_PAGE : rec.next_page;
      end else if (cmd.free_commit) begin
         rec_we               = 1'b1;
         rec_wdata.first_free = free_off;
         rec_wdata.size_class = rec.size_class;
         rec_wdata.next_page  = stat.rec_full ? head_ff[rec.size_class] : rec.next_page;
      end
   end

   // Slot link store: one entry per 8-byte granule of each page.
   assign link_raddr = {pg_ff[PAGE_IDX_W-1:0], rec.first_free[OFF_W-1:OFF_W-GRAN_W]};

   always_comb begin
      link_we    = 1'b0;
      link_waddr = {pg_ff[PAGE_IDX_W-1:0], off_ff[OFF_W-1:OFF_W-GRAN_W]};
      link_wdata = off_ff + OFF_W'(cur_sz);
      if (cmd.open_step) begin
         link_we = 1'b1;
      end else if (cmd.free_commit) begin
         link_we    = 1'b1;
         link_waddr = {pg_ff[PAGE_IDX_W-1:0], free_off[OFF_W-1:OFF_W-GRAN_W]};
         link_wdata = rec.first_free;
      end
   end

   scsa_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_PAGES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   scsa_ram #(
      .WIDTH (OFF_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   always_comb begin
      req_load_in   = req_ff;
      pg_in         = pg_ff;
      off_in        = off_ff;
      pages_used_in = pages_used_ff;
      head_in       = head_ff;
      if (cmd.load) begin
         req_load_in = req_in;
      end
      if (cmd.open_init) begin
         pg_in                 = pages_used_ff;
         off_in                = '0;
         pages_used_in         = pages_used_ff + PAGE_W'(1);
         head_in[req_cls]      = pages_used_ff;
      end else if (cmd.decide) begin
         pg_in = sel_pg;
      end
      if (cmd.open_step) begin
         off_in = off_ff + OFF_W'(cur_sz);
      end
      if (cmd.alloc_commit && after_full) begin
         head_in[req_cls] = rec.next_page;
      end
      if (cmd.free_commit && stat.rec_full) begin
         head_in[rec.size_class] = pg_ff;
      end
      rsp_valid_in        = cmd.respond;
      rsp_in.status       = cmd.code;
      rsp_in.slot_address = (cmd.code == STATUS_ALLOCATED) ? alloc_addr : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_used_ff <= '0;
         head_ff       <= '{default: NO_PAGE};
         rsp_valid_ff  <= 1'b0;
      end else begin
         pages_used_ff <= pages_used_in;
         head_ff       <= head_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_load_in;
      pg_ff  <= pg_in;
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;

   always_comb begin
      heads_ok = 1'b1;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (head_ff[c] != NO_PAGE && head_ff[c] >= pages_used_ff) begin
            heads_ok = 1'b0;
         end
      end
   end

   assign sweep_in_area = !past_end(off_ff, cur_sz);

   `SCSA_ASSERT(a_pages_bounded, 1'b1, pages_used_ff <= PAGE_W'(MAX_PAGES))
   `SCSA_ASSERT(a_heads_opened, 1'b1, heads_ok)
   `SCSA_ASSERT(a_sweep_in_area, cmd.open_step, sweep_in_area)

endmodule

### sv/size_class_slab_allocator.sv
// Channel    Handshake               Payload
// request    start in, busy out      req_item  (req_type, alloc_size, free_address)
// response   rsp_valid out, 1 cycle  rsp_item  (status, slot_address)
//
// A request is taken when start is high and busy is low; its response strobes one cycle.
// Allocate from a listed page runs DECIDE, RECORD, LINK; free runs DECIDE, RECORD.
// Opening a page sweeps its slot chain through the link memory one slot per cycle in OPEN,
// linking 4080 / slot bytes slots (510, 255, 127 or 63) before that allocate goes on.
// The next request can be taken in the cycle its predecessor's response is shown.
// The receiver cannot stall, so only busy ever holds a request off.
// Synchronous reset empties all class lists and pages; the memories are not cleared.

`include "assert_macros.svh"

module size_class_slab_allocator import scsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  alloc_req_type req_item,
   output logic          rsp_valid,
   output alloc_rsp_type rsp_item
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   scsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   scsa_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_in    (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_out   (rsp_item)
   );

   `SCSA_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)
   `SCSA_ASSERT(a_strobe_when_idle, rsp_valid, !busy)

endmodule
